// ----- hw/rtl/gsw_pkg.sv -----
// Shared types, constants and register codes for the gate supervisor watchdog.
package gsw_pkg;

  localparam int unsigned NUM_CHANNELS_DEF = 5;
  localparam int unsigned AGE_BITS_DEF     = 12;

  localparam int unsigned NUM_TIMEOUTS = 5;
  localparam int unsigned TIMEOUT_W    = 12;
  localparam int unsigned HOLD_W       = 16;
  localparam int unsigned STACK_W      = 16;
  localparam int unsigned KICK_W       = 5;

  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef enum logic [2:0] {
    FK_NONE  = 3'd0,
    FK_SIM   = 3'd1,
    FK_CH0   = 3'd2,
    FK_CH1   = 3'd3,
    FK_CH2   = 3'd4,
    FK_CH3   = 3'd5,
    FK_CH4   = 3'd6,
    FK_STACK = 3'd7
  } fault_kind_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TO_SENSOR  = 3'd0,
    REG_TO_SAFETY  = 3'd1,
    REG_TO_GATE    = 3'd2,
    REG_TO_LED     = 3'd3,
    REG_TO_DISPLAY = 3'd4,
    REG_HOLD_TIME  = 3'd5,
    REG_MIN_STACK  = 3'd6,
    REG_SIMULATE   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic                                  simulate;
    logic [STACK_W-1:0]                    min_stack;
    logic [HOLD_W-1:0]                     hold_time;
    logic [NUM_TIMEOUTS-1:0][TIMEOUT_W-1:0] timeout;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    simulate:  1'b0,
    min_stack: 16'd40,
    hold_time: 16'd3000,
    timeout:   {12'd1500, 12'd250, 12'd100, 12'd100, 12'd100}
  };

  typedef struct packed {
    logic        latched;
    fault_kind_e kind;
  } fault_t;

  // Input word, last field in the lowest bits.
  typedef struct packed {
    logic               gate_blocked;
    logic               hold_open;
    logic               allow_open;
    logic               safety_detected;
    logic [STACK_W-1:0] lowest_stack_free;
    logic [KICK_W-1:0]  kick_mask;
  } in_item_t;

  // Result word, last field in the lowest bits.
  typedef struct packed {
    fault_kind_e fault_kind;
    logic        fault_latched;
    logic        red_lamp;
    logic        green_lamp;
    logic        gate_is_open;
  } out_item_t;

  localparam int unsigned IN_ITEM_W  = $bits(in_item_t);
  localparam int unsigned OUT_ITEM_W = $bits(out_item_t);

endpackage

// ----- hw/rtl/gate_supervisor_watchdog_core.sv -----
// Top level of the gate supervisor watchdog: stream ports, registers, pipeline.
//
// Each input word is one millisecond tick and yields exactly one result word.
// The block takes one word per clock cycle when the result side keeps up; a
// word passes the input register, then the result register, and
// all per-tick work (age counters, timeout compares, fault priority, gate and
// hold timer update) is done combinationally between those registers.
// The result register lets a new word enter while an earlier result is still
// waiting to be taken. Configuration writes land at once and are meant to be
// made while no word is in flight. The fault latch is cleared only by reset.
module gate_supervisor_watchdog_core #(
  parameter int unsigned NUM_CHANNELS = gsw_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned AGE_BITS     = gsw_pkg::AGE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // kick_mask[4:0], lowest_stack_free[20:5], safety_detected[21],
  // allow_open[22], hold_open[23], gate_blocked[24], zero above
  input  logic [gsw_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // gate_is_open[0], green_lamp[1], red_lamp[2], fault_latched[3],
  // fault_kind[6:4], zero above
  output logic [gsw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we_i,
  input  logic [gsw_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [gsw_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);
  import gsw_pkg::*;

  cfg_t      cfg_q, cfg_d;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t out_q, out_d;
  logic      out_valid_q;
  logic      adv;
  logic      s_acc;
  fault_t    fault_d, fault_q;
  logic      gate_open, green;

  // Configuration registers.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_TO_SENSOR:  cfg_d.timeout[0] = cfg_wdata_i[TIMEOUT_W-1:0];
        REG_TO_SAFETY:  cfg_d.timeout[1] = cfg_wdata_i[TIMEOUT_W-1:0];
        REG_TO_GATE:    cfg_d.timeout[2] = cfg_wdata_i[TIMEOUT_W-1:0];
        REG_TO_LED:     cfg_d.timeout[3] = cfg_wdata_i[TIMEOUT_W-1:0];
        REG_TO_DISPLAY: cfg_d.timeout[4] = cfg_wdata_i[TIMEOUT_W-1:0];
        REG_HOLD_TIME:  cfg_d.hold_time  = cfg_wdata_i[HOLD_W-1:0];
        REG_MIN_STACK:  cfg_d.min_stack  = cfg_wdata_i[STACK_W-1:0];
        REG_SIMULATE:   cfg_d.simulate   = cfg_wdata_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // A word advances from the input register when the result register is free
  // or being emptied in the same cycle.
  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_acc) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_q <= in_item_t'(s_axis_tdata[IN_ITEM_W-1:0]);
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  gsw_watchdog #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .AGE_BITS     (AGE_BITS)
  ) u_watchdog (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .kick_i       (in_q.kick_mask),
    .stack_free_i (in_q.lowest_stack_free),
    .cfg_i        (cfg_q),
    .fault_d_o    (fault_d),
    .fault_q_o    (fault_q)
  );

  gsw_gate u_gate (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .fault_mode_i (fault_d.latched),
    .safety_i     (in_q.safety_detected),
    .allow_i      (in_q.allow_open),
    .hold_i       (in_q.hold_open),
    .blocked_i    (in_q.gate_blocked),
    .hold_time_i  (cfg_q.hold_time),
    .gate_open_o  (gate_open),
    .green_o      (green)
  );

  always_comb begin
    out_d.gate_is_open  = gate_open;
    out_d.green_lamp    = green;
    out_d.red_lamp      = !green;
    out_d.fault_latched = fault_d.latched;
    out_d.fault_kind    = fault_d.kind;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_q);

  // The fault latch never drops once set.
  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q.latched |=> fault_q.latched)
    else $error("fault latch cleared without reset");

  // A latched fault always carries a fault kind, and no kind exists without it.
  a_fault_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.fault_latched == (out_q.fault_kind != FK_NONE)))
    else $error("fault kind inconsistent with fault latch");

  // In fault mode the green lamp simply mirrors the gate position.
  a_fault_lamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.fault_latched) |-> (out_q.green_lamp == out_q.gate_is_open))
    else $error("green lamp differs from gate in fault mode");

  // The lamps are always complementary.
  a_lamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_q.red_lamp != out_q.green_lamp))
    else $error("red and green lamps not complementary");

endmodule

// ----- hw/rtl/gsw_watchdog.sv -----
// Per-channel heartbeat age counters and the prioritized fault latch.
module gsw_watchdog #(
  parameter int unsigned NUM_CHANNELS = gsw_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned AGE_BITS     = gsw_pkg::AGE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  logic [gsw_pkg::KICK_W-1:0]     kick_i,
  input  logic [gsw_pkg::STACK_W-1:0]    stack_free_i,
  input  gsw_pkg::cfg_t                  cfg_i,
  output gsw_pkg::fault_t                fault_d_o,
  output gsw_pkg::fault_t                fault_q_o
);
  import gsw_pkg::*;

  localparam int unsigned KPAD_W = (NUM_CHANNELS > KICK_W) ? NUM_CHANNELS : KICK_W;
  localparam int unsigned NCHK   = (NUM_CHANNELS < NUM_TIMEOUTS) ? NUM_CHANNELS : NUM_TIMEOUTS;
  localparam int unsigned CMP_W  = (AGE_BITS > TIMEOUT_W) ? AGE_BITS : TIMEOUT_W;

  logic [NUM_CHANNELS-1:0][AGE_BITS-1:0] age_q, age_d;
  logic [KPAD_W-1:0]                     kick_pad;
  logic [NUM_CHANNELS-1:0]               kick_vec;
  logic [2:0]                            code;
  fault_t                                fault_q, fault_d;

  assign kick_pad = KPAD_W'(kick_i);
  assign kick_vec = kick_pad[NUM_CHANNELS-1:0];

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (kick_vec[i]) begin
        age_d[i] = '0;
      end else if (age_q[i] == {AGE_BITS{1'b1}}) begin
        age_d[i] = age_q[i];
      end else begin
        age_d[i] = age_q[i] + AGE_BITS'(1);
      end
    end
  end

  // Walk from the highest checked channel down so the lowest failing one wins.
  always_comb begin
    code = FK_NONE;
    if (cfg_i.simulate) begin
      code = FK_SIM;
    end else begin
      if (stack_free_i < cfg_i.min_stack) begin
        code = FK_STACK;
      end
      for (int i = NCHK - 1; i >= 0; i--) begin
        if (CMP_W'(age_d[i]) > CMP_W'(cfg_i.timeout[i])) begin
          code = FK_CH0 + 3'(i);
        end
      end
    end
  end

  always_comb begin
    fault_d = fault_q;
    if (code != FK_NONE) begin
      fault_d.latched = 1'b1;
      fault_d.kind    = fault_kind_e'(code);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q   <= '0;
      fault_q <= '{latched: 1'b0, kind: FK_NONE};
    end else if (adv_i) begin
      age_q   <= age_d;
      fault_q <= fault_d;
    end
  end

  assign fault_d_o = fault_d;
  assign fault_q_o = fault_q;

endmodule

// ----- hw/rtl/gsw_gate.sv -----
// Gate position and hold timer, normal and fault mode.
module gsw_gate (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        fault_mode_i,
  input  logic                        safety_i,
  input  logic                        allow_i,
  input  logic                        hold_i,
  input  logic                        blocked_i,
  input  logic [gsw_pkg::HOLD_W-1:0]  hold_time_i,
  output logic                        gate_open_o,
  output logic                        green_o
);
  import gsw_pkg::*;

  logic              gate_q, gate_d;
  logic [HOLD_W-1:0] hold_q, hold_d, hold_inc;

  assign hold_inc = (hold_q == {HOLD_W{1'b1}}) ? hold_q : hold_q + HOLD_W'(1);

  always_comb begin
    gate_d  = gate_q;
    hold_d  = hold_q;
    green_o = 1'b0;
    if (fault_mode_i) begin
      // The hold timer is frozen once the gate follows the safety sensor.
      gate_d  = safety_i;
      green_o = safety_i;
    end else begin
      if (!gate_q) begin
        if (allow_i && !blocked_i) begin
          gate_d = 1'b1;
          hold_d = '0;
        end
      end else if (hold_i && !blocked_i) begin
        hold_d = '0;
      end else begin
        hold_d = hold_inc;
        if (hold_inc >= hold_time_i) begin
          gate_d = 1'b0;
        end
      end
      green_o = gate_d && !blocked_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q <= 1'b0;
      hold_q <= '0;
    end else if (adv_i) begin
      gate_q <= gate_d;
      hold_q <= hold_d;
    end
  end

  assign gate_open_o = gate_d;

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the gate supervisor watchdog core.
`timescale 1ns / 100ps

import gsw_pkg::*;

// Tracks the watchdog and gate state tick by tick and checks every result word.
class watchdog_scoreboard;
  logic [TIMEOUT_W-1:0] timeout [NUM_TIMEOUTS];
  logic [HOLD_W-1:0]    hold_time;
  logic [STACK_W-1:0]   min_stack;
  logic                 simulate;

  logic [AGE_BITS_DEF-1:0] age [NUM_TIMEOUTS];
  logic [HOLD_W-1:0]       hold_elapsed;
  logic                    gate_open;
  logic                    fault_seen;
  fault_kind_e             fault_code;

  out_item_t expected_q[$];
  int        errors;

  function new();
    for (int i = 0; i < NUM_TIMEOUTS; i++) begin
      timeout[i] = CFG_RST.timeout[i];
      age[i]     = '0;
    end
    hold_time    = CFG_RST.hold_time;
    min_stack    = CFG_RST.min_stack;
    simulate     = CFG_RST.simulate;
    hold_elapsed = '0;
    gate_open    = 1'b0;
    fault_seen   = 1'b0;
    fault_code   = FK_NONE;
    errors       = 0;
  endfunction

  function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_HOLD_TIME: hold_time = val[HOLD_W-1:0];
      REG_MIN_STACK: min_stack = val[STACK_W-1:0];
      REG_SIMULATE:  simulate  = val[0];
      default:       timeout[int'(idx)] = val[TIMEOUT_W-1:0];
    endcase
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // Advances the model by one tick and queues the result it must produce.
  function void note_tick(in_item_t t);
    fault_kind_e fail;
    logic        green;
    out_item_t   r;
    fail = FK_NONE;
    for (int i = 0; i < NUM_TIMEOUTS; i++) begin
      if (t.kick_mask[i]) age[i] = '0;
      else if (age[i] != '1) age[i] = age[i] + 1'b1;
    end
    if (simulate) begin
      fail = FK_SIM;
    end else begin
      for (int i = 0; i < NUM_TIMEOUTS; i++) begin
        if (fail == FK_NONE && age[i] > timeout[i]) fail = fault_kind_e'(FK_CH0 + i);
      end
      if (fail == FK_NONE && t.lowest_stack_free < min_stack) fail = FK_STACK;
    end
    if (fail != FK_NONE) begin
      fault_seen = 1'b1;
      fault_code = fail;
    end
    // Once a fault is latched the gate just mirrors the safety sensor.
    if (fault_seen) begin
      gate_open = t.safety_detected;
      green     = gate_open;
    end else begin
      if (!gate_open) begin
        if (t.allow_open && !t.gate_blocked) begin
          gate_open    = 1'b1;
          hold_elapsed = '0;
        end
      end else if (t.hold_open && !t.gate_blocked) begin
        hold_elapsed = '0;
      end else begin
        if (hold_elapsed != '1) hold_elapsed = hold_elapsed + 1'b1;
        if (hold_elapsed >= hold_time) gate_open = 1'b0;
      end
      green = gate_open && !t.gate_blocked;
    end
    r.gate_is_open  = gate_open;
    r.green_lamp    = green;
    r.red_lamp      = ~green;
    r.fault_latched = fault_seen;
    r.fault_kind    = fault_code;
    expected_q.push_back(r);
  endfunction

  function void check_result(out_item_t got);
    out_item_t exp;
    if (expected_q.size() == 0) begin
      $error("result word with no expected word pending");
      errors++;
      return;
    end
    exp = expected_q.pop_front();
    if (got.gate_is_open !== exp.gate_is_open) begin
      $error("gate_is_open: expected %0d, got %0d", exp.gate_is_open, got.gate_is_open);
      errors++;
    end
    if (got.green_lamp !== exp.green_lamp) begin
      $error("green_lamp: expected %0d, got %0d", exp.green_lamp, got.green_lamp);
      errors++;
    end
    if (got.red_lamp !== exp.red_lamp) begin
      $error("red_lamp: expected %0d, got %0d", exp.red_lamp, got.red_lamp);
      errors++;
    end
    if (got.fault_latched !== exp.fault_latched) begin
      $error("fault_latched: expected %0d, got %0d", exp.fault_latched, got.fault_latched);
      errors++;
    end
    if (got.fault_kind !== exp.fault_kind) begin
      $error("fault_kind: expected %0d, got %0d", exp.fault_kind, got.fault_kind);
      errors++;
    end
  endfunction
endclass

module testbench;

  typedef enum logic [1:0] {
    RX_STEADY  = 2'd0,
    RX_RANDOM  = 2'd1,
    RX_PATTERN = 2'd2,
    RX_LONG    = 2'd3
  } rx_mode_e;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i   = '0;

  rx_mode_e        rx_mode  = RX_STEADY;
  logic [7:0]      rx_phase = '0;
  logic [CFG_DATA_W-1:0] setting [8];

  watchdog_scoreboard sb;

  gate_supervisor_watchdog_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // Receiver back-pressure; the long mode flips ready rarely to get long stalls.
  always @(posedge clk_i) begin
    rx_phase <= rx_phase + 1'b1;
    case (rx_mode)
      RX_STEADY:  m_axis_tready <= 1'b1;
      RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 3) != 0);
      RX_PATTERN: m_axis_tready <= ((rx_phase % 7) >= 3);
      default:    m_axis_tready <= ($urandom_range(0, 15) == 0) ? ~m_axis_tready : m_axis_tready;
    endcase
  end

  // Result words are checked before the word accepted on the same edge is noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(out_item_t'(m_axis_tdata[OUT_ITEM_W-1:0]));
      if (s_axis_tvalid && s_axis_tready) sb.note_tick(in_item_t'(s_axis_tdata[IN_ITEM_W-1:0]));
    end
  end

  function automatic in_item_t make_tick(logic [KICK_W-1:0] kicks, logic [STACK_W-1:0] stack,
                                         logic safety, logic allow, logic hold, logic blocked);
    in_item_t t;
    t.kick_mask         = kicks;
    t.lowest_stack_free = stack;
    t.safety_detected   = safety;
    t.allow_open        = allow;
    t.hold_open         = hold;
    t.gate_blocked      = blocked;
    return t;
  endfunction

  task automatic send_tick(input in_item_t t);
    s_axis_tdata  <= IN_TDATA_W'(t);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic write_setting();
    for (int r = 0; r < 8; r++) write_reg(cfg_reg_e'(r), setting[r]);
  endtask

  // Lets every word in flight come out before the registers are touched again.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Random ticks in bursts. In normal mode channels 0 to 3 are kicked often enough
  // never to time out, channel 4 is never kicked, and the stack is not below the floor.
  task automatic run_random_ticks(input int count, input bit in_fault, input int stack_floor,
                                  input int gap_max);
    int       sent;
    int       burst;
    int       gap;
    in_item_t t;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      for (int b = 0; b < burst && sent < count; b++) begin
        if (in_fault) begin
          t.kick_mask         = KICK_W'($urandom_range(0, 31));
          t.lowest_stack_free = STACK_W'($urandom_range(0, 65535));
        end else begin
          for (int i = 0; i < 4; i++) t.kick_mask[i] = ($urandom_range(0, 3) != 0);
          t.kick_mask[4]      = 1'b0;
          t.lowest_stack_free = STACK_W'($urandom_range(stack_floor, 65535));
        end
        t.safety_detected = $urandom_range(0, 1);
        t.allow_open      = ($urandom_range(0, 2) == 0);
        t.hold_open       = ($urandom_range(0, 3) == 0);
        t.gate_blocked    = ($urandom_range(0, 4) == 0);
        send_tick(t);
        sent++;
      end
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    int floor_val;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Gate basics under the reset settings, all channels kicked.
    send_tick(make_tick(5'h1f, 16'hffff, 1'b0, 1'b1, 1'b0, 1'b1));
    send_tick(make_tick(5'h1f, 16'hffff, 1'b0, 1'b1, 1'b0, 1'b0));
    send_tick(make_tick(5'h1f, 16'hffff, 1'b0, 1'b0, 1'b1, 1'b1));
    send_tick(make_tick(5'h1f, 16'hffff, 1'b0, 1'b0, 1'b1, 1'b0));
    send_tick(make_tick(5'h1f, 16'hffff, 1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(make_tick(5'h1f, 16'hffff, 1'b1, 1'b0, 1'b0, 1'b0));
    settle();

    // Normal mode: channel 4 is never kicked, and its timeout of 4095 keeps it quiet.
    for (int k = 0; k < 6; k++) begin
      for (int r = 0; r < 4; r++) begin
        setting[r] = (k == 1) ? {4'($urandom), 12'hfff}
                              : {4'($urandom), 12'($urandom_range(16, 4095))};
      end
      setting[REG_TO_DISPLAY] = {4'($urandom), 12'hfff};
      setting[REG_HOLD_TIME]  = (k == 0) ? 16'd0 : (k == 1) ? 16'hffff
                                                  : 16'($urandom_range(1, 40));
      floor_val               = (k == 0) ? 0 : $urandom_range(1, 2000);
      setting[REG_MIN_STACK]  = 16'(floor_val);
      setting[REG_SIMULATE]   = {15'($urandom), 1'b0};
      write_setting();
      if (k == 0) begin
        // A hold time of zero closes the gate on the first tick without a hold.
        send_tick(make_tick(5'h0f, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0));
        send_tick(make_tick(5'h0f, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(make_tick(5'h00, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b1));
      end
      run_random_ticks(150, 1'b0, floor_val, (k % 3 == 2) ? 0 : $urandom_range(1, 6));
      settle();
    end

    // Stack limit at its top: one word short of the limit faults.
    for (int r = 0; r < 5; r++) write_reg(cfg_reg_e'(r), 16'h0fff);
    write_reg(REG_MIN_STACK, 16'hffff);
    send_tick(make_tick(5'h1f, 16'hfffe, 1'b1, 1'b0, 1'b0, 1'b0));
    send_tick(make_tick(5'h1f, 16'hffff, 1'b0, 1'b1, 1'b0, 1'b0));
    send_tick(make_tick(5'h1f, 16'hffff, 1'b1, 1'b0, 1'b1, 1'b1));
    settle();

    // Zero timeouts: each missing kick names its channel, the lowest channel wins.
    for (int r = 0; r < 5; r++) write_reg(cfg_reg_e'(r), 16'h0000);
    send_tick(make_tick(5'h1e, 16'hffff, 1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(make_tick(5'h1d, 16'hffff, 1'b1, 1'b0, 1'b0, 1'b0));
    send_tick(make_tick(5'h1b, 16'hffff, 1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(make_tick(5'h17, 16'hffff, 1'b1, 1'b0, 1'b0, 1'b0));
    send_tick(make_tick(5'h0f, 16'hffff, 1'b0, 1'b0, 1'b0, 1'b0));
    send_tick(make_tick(5'h00, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0));
    send_tick(make_tick(5'h1f, 16'hffff, 1'b0, 1'b0, 1'b0, 1'b0));
    settle();
    write_reg(REG_SIMULATE, 16'h0001);
    send_tick(make_tick(5'h00, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0));
    settle();

    // Fault mode with small timeouts so that every fault kind keeps turning up.
    for (int k = 0; k < 4; k++) begin
      for (int r = 0; r < 5; r++) setting[r] = {4'($urandom), 12'($urandom_range(0, 12))};
      setting[REG_HOLD_TIME] = 16'($urandom);
      setting[REG_MIN_STACK] = 16'($urandom);
      setting[REG_SIMULATE]  = (k == 3) ? 16'h0001
                                        : {15'($urandom), 1'($urandom_range(0, 3) == 0)};
      write_setting();
      run_random_ticks(100, 1'b1, 0, (k == 1) ? 0 : $urandom_range(1, 6));
      settle();
    end

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
